// ===== src/encoder_move_command_sequencer_core_defines.svh =====
// Assertion helpers for the move command sequencer.
// Both expect signals named clk and rst_n in the using scope.
`ifndef ENCODER_MOVE_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define ENCODER_MOVE_COMMAND_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define EMCS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("emcs same-cycle check failed");

// next-cycle implication
`define EMCS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("emcs next-cycle check failed");

`endif

// ===== src/emcs_pkg.sv =====
`default_nettype none

package emcs_pkg;

  // default widths and reset values
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TIMER_WIDTH_DEF = 32;
  localparam logic [31:0] BUZZER_TICKS_RST = 32'd7000;
  localparam logic [7:0]  DUTY_RST = 8'hFF;

  // register index of buzzer_ticks
  localparam logic REG_BUZZER_TICKS = 1'b0;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    CMD_BYTE        = 2'd0,
    CMD_LEFT_PULSE  = 2'd1,
    CMD_RIGHT_PULSE = 2'd2,
    CMD_TICK        = 2'd3
  } cmd_code_t;

  // execution phase
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_STRAIGHT = 3'd1,
    PH_TURN     = 3'd2,
    PH_APPROACH = 3'd3,
    PH_BUZZ     = 3'd4
  } phase_t;

  // what a command byte does
  typedef enum logic [2:0] {
    CK_STOP    = 3'd0,
    CK_MOVE    = 3'd1,
    CK_BUZZ    = 3'd2,
    CK_LED_SET = 3'd3,
    CK_LED_CLR = 3'd4,
    CK_NONE    = 3'd5
  } cmd_kind_t;

  // command bytes
  localparam logic [7:0] CB_STOP          = 8'h00;
  localparam logic [7:0] CB_FWD_267       = 8'h01;
  localparam logic [7:0] CB_BACK_108      = 8'h02;
  localparam logic [7:0] CB_APPR_RIGHT    = 8'h03;
  localparam logic [7:0] CB_APPR_LEFT     = 8'h04;
  localparam logic [7:0] CB_FWD_140       = 8'h05;
  localparam logic [7:0] CB_BUZZ          = 8'h06;
  localparam logic [7:0] CB_LED_SET_A     = 8'h07;
  localparam logic [7:0] CB_LED_SET_B     = 8'h08;
  localparam logic [7:0] CB_LED_SET_C     = 8'h09;
  localparam logic [7:0] CB_LED_SET_D     = 8'h0A;
  localparam logic [7:0] CB_LED_SET_E     = 8'h0B;
  localparam logic [7:0] CB_LED_SET_F     = 8'h0C;
  localparam logic [7:0] CB_LED_CLR_A     = 8'h0D;
  localparam logic [7:0] CB_LED_CLR_B     = 8'h0E;
  localparam logic [7:0] CB_LED_CLR_C     = 8'h0F;
  localparam logic [7:0] CB_LED_CLR_D     = 8'h10;
  localparam logic [7:0] CB_LED_CLR_E     = 8'h11;
  localparam logic [7:0] CB_LED_CLR_F     = 8'h12;
  localparam logic [7:0] CB_SPIN_R_180    = 8'h13;
  localparam logic [7:0] CB_FWD_237       = 8'h14;
  localparam logic [7:0] CB_SPIN_L_180    = 8'h15;
  localparam logic [7:0] CB_FWD_90        = 8'h16;
  localparam logic [7:0] CB_FWD_95        = 8'h17;

  // drive direction codes
  localparam logic [3:0] DIR_STOP   = 4'h0;
  localparam logic [3:0] DIR_FWD    = 4'h6;
  localparam logic [3:0] DIR_BACK   = 4'h9;
  localparam logic [3:0] DIR_SPIN_R = 4'hA;
  localparam logic [3:0] DIR_SPIN_L = 4'h5;

  // pulse targets: mm / 5.44 or deg / 4.09, truncated
  localparam logic [5:0] TGT_267   = 6'd49;
  localparam logic [5:0] TGT_108   = 6'd19;
  localparam logic [5:0] TGT_30    = 6'd5;
  localparam logic [5:0] TGT_140   = 6'd25;
  localparam logic [5:0] TGT_237   = 6'd43;
  localparam logic [5:0] TGT_90MM  = 6'd16;
  localparam logic [5:0] TGT_95    = 6'd17;
  localparam logic [5:0] TGT_90DEG = 6'd22;
  localparam logic [5:0] TGT_180   = 6'd44;

  // LED bits
  localparam logic [7:0] LED_A = 8'h01;
  localparam logic [7:0] LED_B = 8'h08;
  localparam logic [7:0] LED_C = 8'h04;
  localparam logic [7:0] LED_D = 8'h10;
  localparam logic [7:0] LED_E = 8'h80;
  localparam logic [7:0] LED_F = 8'h40;

  // decoded command
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] left_duty;
    logic [7:0] right_duty;
    logic [3:0] dir;
    phase_t     phase;
    logic [5:0] target;
    logic [7:0] led_mask;
  } cmd_info_t;

  // one result item
  typedef struct packed {
    logic [3:0] drive_dir;
    logic [7:0] left_duty;
    logic [7:0] right_duty;
    logic [7:0] led_bits;
    logic       buzz_level;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       busy_res;
    logic       dropped;
  } result_t;

endpackage

`default_nettype wire

// ===== src/emcs_decode.sv =====
`default_nettype none

// Command byte lookup: duties, direction, phase, target, LED bit.
module emcs_decode (
  input  wire logic [7:0]          rx_byte,
  output emcs_pkg::cmd_info_t      info
);

  always_comb begin
    info = '{kind: emcs_pkg::CK_NONE, left_duty: 8'd0, right_duty: 8'd0,
             dir: emcs_pkg::DIR_STOP, phase: emcs_pkg::PH_IDLE, target: 6'd0,
             led_mask: 8'd0};
    unique case (rx_byte)
      emcs_pkg::CB_STOP: info.kind = emcs_pkg::CK_STOP;
      emcs_pkg::CB_FWD_267: begin
        info = '{emcs_pkg::CK_MOVE, 8'd225, 8'd205, emcs_pkg::DIR_FWD,
                 emcs_pkg::PH_STRAIGHT, emcs_pkg::TGT_267, 8'd0};
      end
      emcs_pkg::CB_BACK_108: begin
        info = '{emcs_pkg::CK_MOVE, 8'd225, 8'd205, emcs_pkg::DIR_BACK,
                 emcs_pkg::PH_STRAIGHT, emcs_pkg::TGT_108, 8'd0};
      end
      emcs_pkg::CB_APPR_RIGHT: begin
        info = '{emcs_pkg::CK_MOVE, 8'd160, 8'd150, emcs_pkg::DIR_FWD,
                 emcs_pkg::PH_APPROACH, emcs_pkg::TGT_30, 8'd0};
      end
      emcs_pkg::CB_APPR_LEFT: begin
        info = '{emcs_pkg::CK_MOVE, 8'd156, 8'd149, emcs_pkg::DIR_FWD,
                 emcs_pkg::PH_APPROACH, emcs_pkg::TGT_30, 8'd0};
      end
      emcs_pkg::CB_FWD_140: begin
        info = '{emcs_pkg::CK_MOVE, 8'd225, 8'd205, emcs_pkg::DIR_FWD,
                 emcs_pkg::PH_STRAIGHT, emcs_pkg::TGT_140, 8'd0};
      end
      emcs_pkg::CB_SPIN_R_180: begin
        info = '{emcs_pkg::CK_MOVE, 8'd153, 8'd149, emcs_pkg::DIR_SPIN_R,
                 emcs_pkg::PH_TURN, emcs_pkg::TGT_180, 8'd0};
      end
      emcs_pkg::CB_FWD_237: begin
        info = '{emcs_pkg::CK_MOVE, 8'd225, 8'd205, emcs_pkg::DIR_FWD,
                 emcs_pkg::PH_STRAIGHT, emcs_pkg::TGT_237, 8'd0};
      end
      emcs_pkg::CB_SPIN_L_180: begin
        info = '{emcs_pkg::CK_MOVE, 8'd154, 8'd149, emcs_pkg::DIR_SPIN_L,
                 emcs_pkg::PH_TURN, emcs_pkg::TGT_180, 8'd0};
      end
      emcs_pkg::CB_FWD_90: begin
        info = '{emcs_pkg::CK_MOVE, 8'd225, 8'd205, emcs_pkg::DIR_FWD,
                 emcs_pkg::PH_STRAIGHT, emcs_pkg::TGT_90MM, 8'd0};
      end
      emcs_pkg::CB_FWD_95: begin
        info = '{emcs_pkg::CK_MOVE, 8'd225, 8'd205, emcs_pkg::DIR_FWD,
                 emcs_pkg::PH_STRAIGHT, emcs_pkg::TGT_95, 8'd0};
      end
      emcs_pkg::CB_BUZZ: info.kind = emcs_pkg::CK_BUZZ;
      // LED set codes
      emcs_pkg::CB_LED_SET_A: begin
        info.kind = emcs_pkg::CK_LED_SET; info.led_mask = emcs_pkg::LED_A;
      end
      emcs_pkg::CB_LED_SET_B: begin
        info.kind = emcs_pkg::CK_LED_SET; info.led_mask = emcs_pkg::LED_B;
      end
      emcs_pkg::CB_LED_SET_C: begin
        info.kind = emcs_pkg::CK_LED_SET; info.led_mask = emcs_pkg::LED_C;
      end
      emcs_pkg::CB_LED_SET_D: begin
        info.kind = emcs_pkg::CK_LED_SET; info.led_mask = emcs_pkg::LED_D;
      end
      emcs_pkg::CB_LED_SET_E: begin
        info.kind = emcs_pkg::CK_LED_SET; info.led_mask = emcs_pkg::LED_E;
      end
      emcs_pkg::CB_LED_SET_F: begin
        info.kind = emcs_pkg::CK_LED_SET; info.led_mask = emcs_pkg::LED_F;
      end
      // LED clear codes
      emcs_pkg::CB_LED_CLR_A: begin
        info.kind = emcs_pkg::CK_LED_CLR; info.led_mask = emcs_pkg::LED_A;
      end
      emcs_pkg::CB_LED_CLR_B: begin
        info.kind = emcs_pkg::CK_LED_CLR; info.led_mask = emcs_pkg::LED_B;
      end
      emcs_pkg::CB_LED_CLR_C: begin
        info.kind = emcs_pkg::CK_LED_CLR; info.led_mask = emcs_pkg::LED_C;
      end
      emcs_pkg::CB_LED_CLR_D: begin
        info.kind = emcs_pkg::CK_LED_CLR; info.led_mask = emcs_pkg::LED_D;
      end
      emcs_pkg::CB_LED_CLR_E: begin
        info.kind = emcs_pkg::CK_LED_CLR; info.led_mask = emcs_pkg::LED_E;
      end
      emcs_pkg::CB_LED_CLR_F: begin
        info.kind = emcs_pkg::CK_LED_CLR; info.led_mask = emcs_pkg::LED_F;
      end
      default: info.kind = emcs_pkg::CK_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/emcs_exec.sv =====
`default_nettype none

// Sequencer state and the single-pass update for one item.
module emcs_exec #(
  parameter int COUNT_WIDTH = emcs_pkg::COUNT_WIDTH_DEF,
  parameter int TIMER_WIDTH = emcs_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire logic [1:0]        command,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [31:0]       buzzer_ticks,
  output emcs_pkg::result_t      res
);

  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

  emcs_pkg::cmd_info_t info;

  emcs_pkg::phase_t         phase_r, phase_nxt;
  logic [7:0]               cur_cmd_r, cur_cmd_nxt;
  logic [COUNT_WIDTH-1:0]   left_cnt_r, left_cnt_nxt;
  logic [COUNT_WIDTH-1:0]   right_cnt_r, right_cnt_nxt;
  logic [5:0]               target_r, target_nxt;
  logic [3:0]               dir_r, dir_nxt;
  logic [7:0]               left_duty_r, left_duty_nxt;
  logic [7:0]               right_duty_r, right_duty_nxt;
  logic [7:0]               led_r, led_nxt;
  logic [TIMER_WIDTH-1:0]   timer_r, timer_nxt;
  logic [TIMER_WIDTH-1:0]   timer_load;
  logic                     done;
  logic                     drop;
  logic                     busy;
  logic                     right_hit;
  logic                     left_hit;

  emcs_decode u_decode (
    .rx_byte (rx_byte),
    .info    (info)
  );

  assign busy = (phase_r != emcs_pkg::PH_IDLE);

  // buzzer length saturates at the timer range
  assign timer_load = (buzzer_ticks > TIMER_MAX) ? TIMER_MAX[TIMER_WIDTH-1:0]
                                                 : buzzer_ticks[TIMER_WIDTH-1:0];

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    cur_cmd_nxt    = cur_cmd_r;
    left_cnt_nxt   = left_cnt_r;
    right_cnt_nxt  = right_cnt_r;
    target_nxt     = target_r;
    dir_nxt        = dir_r;
    left_duty_nxt  = left_duty_r;
    right_duty_nxt = right_duty_r;
    led_nxt        = led_r;
    timer_nxt      = timer_r;
    done           = 1'b0;
    drop           = 1'b0;

    // item effect
    unique case (emcs_pkg::cmd_code_t'(command))
      emcs_pkg::CMD_BYTE: begin
        if (busy) begin
          drop = 1'b1;
        end else begin
          cur_cmd_nxt = rx_byte;
          unique case (info.kind)
            emcs_pkg::CK_STOP: begin
              dir_nxt = emcs_pkg::DIR_STOP;
              done    = 1'b1;
            end
            emcs_pkg::CK_MOVE: begin
              left_duty_nxt  = info.left_duty;
              right_duty_nxt = info.right_duty;
              dir_nxt        = info.dir;
              phase_nxt      = info.phase;
              target_nxt     = info.target;
              right_cnt_nxt  = '0;
              if (info.phase == emcs_pkg::PH_TURN) begin
                left_cnt_nxt = '0;
              end
            end
            emcs_pkg::CK_BUZZ: begin
              timer_nxt = timer_load;
              if (timer_load == '0) begin
                done = 1'b1;
              end else begin
                phase_nxt = emcs_pkg::PH_BUZZ;
              end
            end
            emcs_pkg::CK_LED_SET: begin
              led_nxt = led_r | info.led_mask;
              done    = 1'b1;
            end
            emcs_pkg::CK_LED_CLR: begin
              led_nxt = led_r & ~info.led_mask;
              done    = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
      end
      emcs_pkg::CMD_LEFT_PULSE:  left_cnt_nxt  = left_cnt_r + 1'b1;
      emcs_pkg::CMD_RIGHT_PULSE: right_cnt_nxt = right_cnt_r + 1'b1;
      emcs_pkg::CMD_TICK: begin
        if (phase_r == emcs_pkg::PH_BUZZ) begin
          timer_nxt = timer_r - 1'b1;
          if (timer_nxt == '0) begin
            done = 1'b1;
          end
        end
      end
    endcase

    // target check on the updated counts
    right_hit = (right_cnt_nxt >= COUNT_WIDTH'(target_nxt));
    left_hit  = (left_cnt_nxt >= COUNT_WIDTH'(target_nxt));
    if (phase_nxt == emcs_pkg::PH_STRAIGHT || phase_nxt == emcs_pkg::PH_APPROACH) begin
      if (right_hit) begin
        if (phase_nxt == emcs_pkg::PH_APPROACH) begin
          // approach done: start the 90 degree turn
          dir_nxt = (cur_cmd_nxt == emcs_pkg::CB_APPR_RIGHT) ? emcs_pkg::DIR_SPIN_R
                                                              : emcs_pkg::DIR_SPIN_L;
          phase_nxt     = emcs_pkg::PH_TURN;
          target_nxt    = emcs_pkg::TGT_90DEG;
          right_cnt_nxt = '0;
          left_cnt_nxt  = '0;
        end else begin
          dir_nxt = emcs_pkg::DIR_STOP;
          done    = 1'b1;
        end
      end
    end else if (phase_nxt == emcs_pkg::PH_TURN) begin
      if (right_hit || left_hit) begin
        dir_nxt = emcs_pkg::DIR_STOP;
        done    = 1'b1;
      end
    end

    if (done) begin
      phase_nxt = emcs_pkg::PH_IDLE;
      timer_nxt = '0;
    end
  end

  // result item
  always_comb begin
    res.drive_dir  = dir_nxt;
    res.left_duty  = left_duty_nxt;
    res.right_duty = right_duty_nxt;
    res.led_bits   = led_nxt;
    res.buzz_level = (phase_nxt == emcs_pkg::PH_BUZZ);
    res.echo_valid = done;
    res.echo_byte  = done ? cur_cmd_nxt : 8'd0;
    res.busy_res   = (phase_nxt != emcs_pkg::PH_IDLE);
    res.dropped    = drop;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= emcs_pkg::PH_IDLE;
      cur_cmd_r    <= 8'd0;
      left_cnt_r   <= '0;
      right_cnt_r  <= '0;
      target_r     <= 6'd0;
      dir_r        <= emcs_pkg::DIR_STOP;
      left_duty_r  <= emcs_pkg::DUTY_RST;
      right_duty_r <= emcs_pkg::DUTY_RST;
      led_r        <= 8'd0;
      timer_r      <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      cur_cmd_r    <= cur_cmd_nxt;
      left_cnt_r   <= left_cnt_nxt;
      right_cnt_r  <= right_cnt_nxt;
      target_r     <= target_nxt;
      dir_r        <= dir_nxt;
      left_duty_r  <= left_duty_nxt;
      right_duty_r <= right_duty_nxt;
      led_r        <= led_nxt;
      timer_r      <= timer_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/encoder_move_command_sequencer_core.sv =====
// Path: input register, then result register. One item per cycle unless out_stall
// holds a waiting result; the single-pass state update bounds the rate.
// A result waiting under out_stall holds; the input register still takes one more item.
// Reset (rst_n low, synchronous): sequencer idle, counts and timer cleared,
// duties 255, LEDs off, buzzer_ticks 7000, both channels empty.
`default_nettype none

`include "encoder_move_command_sequencer_core_defines.svh"

module encoder_move_command_sequencer_core #(
  parameter int COUNT_WIDTH = emcs_pkg::COUNT_WIDTH_DEF,
  parameter int TIMER_WIDTH = emcs_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_drive_dir,
  output logic [7:0]       out_left_duty,
  output logic [7:0]       out_right_duty,
  output logic [7:0]       out_led_bits,
  output logic             out_buzz_level,
  output logic             out_echo_valid,
  output logic [7:0]       out_echo_byte,
  output logic             out_busy_res,
  output logic             out_dropped,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic              in_valid_r, in_valid_nxt;
  logic [1:0]        in_command_r;
  logic [7:0]        in_rx_byte_r;
  logic              out_valid_r, out_valid_nxt;
  emcs_pkg::result_t res;
  emcs_pkg::result_t res_r;
  logic [31:0]       buzzer_ticks_r;
  logic              out_free;
  logic              step_en;
  logic              in_take;
  logic              cfg_wr;

  // handshake
  assign out_free      = !out_valid_r || !out_stall;
  assign step_en       = in_valid_r && out_free;
  assign in_stall      = in_valid_r && !out_free;
  assign in_take       = in_valid && !in_stall;
  assign in_valid_nxt  = in_take || (in_valid_r && !step_en);
  assign out_valid_nxt = step_en || (out_valid_r && out_stall);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_command_r <= in_command;
      in_rx_byte_r <= in_rx_byte;
    end
  end

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == emcs_pkg::REG_BUZZER_TICKS);
  assign prdata = (paddr[2] == emcs_pkg::REG_BUZZER_TICKS) ? buzzer_ticks_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buzzer_ticks_r <= emcs_pkg::BUZZER_TICKS_RST;
    end else if (cfg_wr) begin
      buzzer_ticks_r <= pwdata;
    end
  end

  // sequencer
  emcs_exec #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_exec (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .command      (in_command_r),
    .rx_byte      (in_rx_byte_r),
    .buzzer_ticks (buzzer_ticks_r),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive_dir  = res_r.drive_dir;
  assign out_left_duty  = res_r.left_duty;
  assign out_right_duty = res_r.right_duty;
  assign out_led_bits   = res_r.led_bits;
  assign out_buzz_level = res_r.buzz_level;
  assign out_echo_valid = res_r.echo_valid;
  assign out_echo_byte  = res_r.echo_byte;
  assign out_busy_res   = res_r.busy_res;
  assign out_dropped    = res_r.dropped;

  // checks
  `EMCS_ASSERT_IMPL(a_echo_not_busy, out_valid && out_echo_valid, !out_busy_res)
  `EMCS_ASSERT_IMPL(a_drop_no_echo, out_valid && out_dropped, !out_echo_valid && out_busy_res)
  `EMCS_ASSERT_IMPL(a_buzz_is_busy, out_valid && out_buzz_level, out_busy_res)
  `EMCS_ASSERT_NEXT(a_step_fills_out, step_en, out_valid)

endmodule

`default_nettype wire
